>>> design/option_payoff_running_stats_defines.svh
// ----------------------------------------------------------------------------
// option_payoff_running_stats_defines
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef OPTION_PAYOFF_RUNNING_STATS_DEFINES_SVH
`define OPTION_PAYOFF_RUNNING_STATS_DEFINES_SVH

// condition at this edge implies consequence at the next edge
`define OPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition implies consequence at the same edge
`define OPS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/ops_pkg.sv
// ----------------------------------------------------------------------------
// ops_pkg
// widths, register codes and controller/datapath structs for the payoff stats
// ----------------------------------------------------------------------------
package ops_pkg;

	localparam int COUNT_BITS = 24;
	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int M2_W       = 64;
	localparam int DEN_W      = 2 * COUNT_BITS;
	localparam int DF_W       = FRAC_BITS + 1;
	localparam int DIV_CNT_W  = $clog2(M2_W + 1);
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CALL     = 2'd2;

	localparam logic [DATA_W-1:0] STRIKE_RST = 32'd6553600;
	localparam logic [DF_W-1:0]   DF_RST     = DF_W'(1) << FRAC_BITS;
	localparam logic              CALL_RST   = 1'b1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic load_in;
		logic calc_pay;
		logic calc_x;
		logic div_mean;
		logic upd_mean;
		logic calc_d2;
		logic calc_prod;
		logic acc_m2;
		logic calc_den;
		logic div_var;
		logic sqrt_start;
		logic post;
	} ops_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic last_path;
		logic multi;
		logic out_free;
	} ops_sts_t;

endpackage

>>> design/ops_in_if.sv
// ----------------------------------------------------------------------------
// ops_in_if
// input channel: one simulated terminal spot per transaction
// ----------------------------------------------------------------------------
interface ops_in_if
	import ops_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] spot_value;
	logic              last_path;

	modport source (output valid, output spot_value, output last_path, input ready);
	modport sink (input valid, input spot_value, input last_path, output ready);
endinterface

>>> design/ops_out_if.sv
// ----------------------------------------------------------------------------
// ops_out_if
// result channel: batch mean and standard error per transaction
// ----------------------------------------------------------------------------
interface ops_out_if
	import ops_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] price_mean;
	logic [DATA_W-1:0] std_error;

	modport source (output valid, output price_mean, output std_error, input ready);
	modport sink (input valid, input price_mean, input std_error, output ready);
endinterface

>>> design/ops_div.sv
// ----------------------------------------------------------------------------
// ops_div
// restoring divider, one quotient bit per cycle, short or long dividend
// ----------------------------------------------------------------------------
module ops_div
	import ops_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             long_op,
	input  logic [M2_W-1:0]  dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [M2_W-1:0]  quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [M2_W-1:0]      quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     dsr_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 fits;

	// short dividends sit in the top bits, so fewer steps give the same quotient
	assign trial = {rem_q, quo_q[M2_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_op ? DIV_CNT_W'(M2_W) : DIV_CNT_W'(DATA_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[M2_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

>>> design/ops_dp.sv
// ----------------------------------------------------------------------------
// ops_dp
// datapath: payoff, discount, welford update, variance divide and square root
// ----------------------------------------------------------------------------
module ops_dp
	import ops_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ops_cmd_t             cmd,
	output ops_sts_t             sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic [DATA_W-1:0]    spot_value,
	input  logic                 last_path,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    price_mean,
	output logic [DATA_W-1:0]    std_error
);

	localparam int PROD_W = DATA_W + DF_W;

	// configuration
	logic [DATA_W-1:0] strike_q;
	logic [DF_W-1:0]   df_q;
	logic              call_q;

	// batch state
	logic [COUNT_BITS-1:0] count_q;
	logic [DATA_W-1:0]     mean_q;
	logic [M2_W-1:0]       m2_q;

	// working registers
	logic [DATA_W-1:0] spot_q;
	logic              last_q;
	logic [DATA_W-1:0] pay_q;
	logic [DATA_W-1:0] x_q;
	logic              neg_q;
	logic [DATA_W-1:0] ad_q;
	logic [DATA_W-1:0] ad2_q;
	logic [M2_W-1:0]   prod_q;
	logic [DEN_W-1:0]  den_q;

	// square root
	logic [M2_W-1:0] sq_v_q;
	logic [M2_W-1:0] sq_res_q;
	logic [M2_W-1:0] sq_bit_q;
	logic [M2_W:0]   sq_sum;
	logic            sq_ge;

	// result slot
	logic              out_valid_q;
	logic [DATA_W-1:0] out_mean_q;
	logic [DATA_W-1:0] out_se_q;

	logic [PROD_W-1:0]       scaled_full;
	logic [DATA_W:0]         scaled;
	logic [DATA_W-1:0]       x_sat;
	logic [COUNT_BITS-1:0]   count_inc;
	logic                    x_lt_mean;
	logic [DATA_W-1:0]       abs_xm;
	logic [DATA_W-1:0]       q_mean;
	logic [M2_W:0]           m2_sum;
	logic [DATA_W-1:0]       se;
	logic                    div_start;
	logic                    div_long;
	logic [M2_W-1:0]         div_dividend;
	logic [DEN_W-1:0]        div_divisor;
	logic                    div_busy;
	logic [M2_W-1:0]         div_quot;
	logic                    out_free;

	assign scaled_full = PROD_W'(pay_q) * PROD_W'(df_q);
	assign scaled      = scaled_full[PROD_W-1:FRAC_BITS];
	assign x_sat       = scaled[DATA_W] ? {DATA_W{1'b1}} : scaled[DATA_W-1:0];
	assign count_inc   = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;

	assign x_lt_mean = x_q < mean_q;
	assign abs_xm    = x_lt_mean ? mean_q - x_q : x_q - mean_q;
	assign q_mean    = div_quot[DATA_W-1:0];
	assign m2_sum    = {1'b0, m2_q} + {1'b0, prod_q};

	assign sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign sq_ge  = {1'b0, sq_v_q} >= sq_sum;
	assign se     = (|sq_res_q[M2_W-1:DATA_W]) ? {DATA_W{1'b1}} : sq_res_q[DATA_W-1:0];

	assign div_start    = cmd.div_mean | cmd.div_var;
	assign div_long     = cmd.div_var;
	assign div_dividend = cmd.div_var ? m2_q : {abs_xm, {(M2_W-DATA_W){1'b0}}};
	assign div_divisor  = cmd.div_var ? den_q : DEN_W'(count_q);

	ops_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_op  (div_long),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_q <= STRIKE_RST;
			df_q     <= DF_RST;
			call_q   <= CALL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STRIKE:   strike_q <= cfg_data;
				CFG_DISCOUNT: df_q     <= cfg_data[DF_W-1:0];
				CFG_CALL:     call_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else if (cmd.post) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else begin
			if (cmd.calc_x)
				count_q <= count_inc;
			if (cmd.upd_mean)
				mean_q <= neg_q ? mean_q - q_mean : mean_q + q_mean;
			if (cmd.acc_m2)
				m2_q <= m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			spot_q <= spot_value;
			last_q <= last_path;
		end
		if (cmd.calc_pay) begin
			if (call_q)
				pay_q <= (spot_q > strike_q) ? spot_q - strike_q : '0;
			else
				pay_q <= (strike_q > spot_q) ? strike_q - spot_q : '0;
		end
		if (cmd.calc_x)
			x_q <= x_sat;
		if (cmd.div_mean) begin
			neg_q <= x_lt_mean;
			ad_q  <= abs_xm;
		end
		if (cmd.calc_d2)
			ad2_q <= abs_xm;
		if (cmd.calc_prod)
			prod_q <= M2_W'(ad_q) * M2_W'(ad2_q);
		if (cmd.calc_den)
			den_q <= DEN_W'(count_q - 1'b1) * DEN_W'(count_q);
	end

	// bit-pair square root, one result bit retired per radicand bit pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_bit_q <= '0;
		else if (cmd.sqrt_start)
			sq_bit_q <= M2_W'(1) << (M2_W - 2);
		else if (|sq_bit_q)
			sq_bit_q <= sq_bit_q >> 2;
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q   <= div_quot;
			sq_res_q <= '0;
		end else if (|sq_bit_q) begin
			if (sq_ge) begin
				sq_v_q   <= sq_v_q - sq_sum[M2_W-1:0];
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.post)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_mean_q <= mean_q;
			out_se_q   <= (count_q > COUNT_BITS'(1)) ? se : '0;
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.sqrt_busy = |sq_bit_q;
	assign sts.last_path = last_q;
	assign sts.multi     = count_q > COUNT_BITS'(1);
	assign sts.out_free  = out_free;

	assign out_valid  = out_valid_q;
	assign price_mean = out_mean_q;
	assign std_error  = out_se_q;

endmodule

>>> design/ops_ctrl.sv
// ----------------------------------------------------------------------------
// ops_ctrl
// sequencer for one path update and the end-of-batch statistics
// ----------------------------------------------------------------------------
module ops_ctrl
	import ops_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ops_sts_t sts,
	output ops_cmd_t cmd
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'h0001,
		ST_PAY    = 15'h0002,
		ST_SCALE  = 15'h0004,
		ST_DELTA  = 15'h0008,
		ST_DIVM   = 15'h0010,
		ST_MEAN   = 15'h0020,
		ST_D2     = 15'h0040,
		ST_PROD   = 15'h0080,
		ST_ACC    = 15'h0100,
		ST_DEN    = 15'h0200,
		ST_VDIV   = 15'h0400,
		ST_VWAIT  = 15'h0800,
		ST_SQST   = 15'h1000,
		ST_SQWAIT = 15'h2000,
		ST_POST   = 15'h4000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_PAY;
			ST_PAY:    state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_DELTA;
			ST_DELTA:  state_d = ST_DIVM;
			ST_DIVM:   if (!sts.div_busy) state_d = ST_MEAN;
			ST_MEAN:   state_d = ST_D2;
			ST_D2:     state_d = ST_PROD;
			ST_PROD:   state_d = ST_ACC;
			ST_ACC: begin
				if (!sts.last_path)
					state_d = ST_IDLE;
				else if (sts.multi)
					state_d = ST_DEN;
				else
					state_d = ST_POST;
			end
			ST_DEN:    state_d = ST_VDIV;
			ST_VDIV:   state_d = ST_VWAIT;
			ST_VWAIT:  if (!sts.div_busy) state_d = ST_SQST;
			ST_SQST:   state_d = ST_SQWAIT;
			ST_SQWAIT: if (!sts.sqrt_busy) state_d = ST_POST;
			ST_POST:   if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd            = '0;
		cmd.load_in    = (state_q == ST_IDLE) && in_valid;
		cmd.calc_pay   = state_q == ST_PAY;
		cmd.calc_x     = state_q == ST_SCALE;
		cmd.div_mean   = state_q == ST_DELTA;
		cmd.upd_mean   = (state_q == ST_DIVM) && !sts.div_busy;
		cmd.calc_d2    = state_q == ST_D2;
		cmd.calc_prod  = state_q == ST_PROD;
		cmd.acc_m2     = state_q == ST_ACC;
		cmd.calc_den   = state_q == ST_DEN;
		cmd.div_var    = state_q == ST_VDIV;
		cmd.sqrt_start = state_q == ST_SQST;
		cmd.post       = (state_q == ST_POST) && sts.out_free;
	end

endmodule

>>> design/option_payoff_running_stats.sv
// ----------------------------------------------------------------------------
// option_payoff_running_stats
// streaming call/put payoff statistics: welford mean and standard error
// ----------------------------------------------------------------------------
// Each spot transaction is turned into a discounted payoff and folded into a
// running mean and M2. An ordinary path keeps the input busy from acceptance
// to the next ready, mostly for the 32 steps of the shared restoring divider
// that divides the deviation by the path count. A path marked last then also
// takes a 64-step divide of M2 by (n-1)n in the same divider, then a 32-step
// square root, before the mean and standard error go to the result register;
// with a single-path batch these steps are skipped. The result register lets
// the next batch start while a result waits to be taken. Configuration is to be
// written by the user only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module option_payoff_running_stats
	import ops_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ops_in_if.sink               samples,
	ops_out_if.source            results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	ops_cmd_t cmd;
	ops_sts_t sts;
	logic     in_ready;

	ops_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ops_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.spot_value (samples.spot_value),
		.last_path  (samples.last_path),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.price_mean (results.price_mean),
		.std_error  (results.std_error)
	);

	assign samples.ready = in_ready;

endmodule

>>> design/ops_checker.sv
// ----------------------------------------------------------------------------
// ops_checker
// port-level checks on the payoff stats block, bound to the top level
// ----------------------------------------------------------------------------
`include "option_payoff_running_stats_defines.svh"

module ops_checker
	import ops_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] price_mean,
	input logic [DATA_W-1:0] std_error
);

	`OPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`OPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(price_mean) && $stable(std_error), "result changed while stalled")
	`OPS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken while busy")
	`OPS_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result raised with an accepted path")

endmodule

bind option_payoff_running_stats ops_checker u_ops_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.price_mean (results.price_mean),
	.std_error  (results.std_error)
);
